// ===== sv/hrap_pkg.sv =====
// Types and constants shared by the history ring autoscale plot block.
package hrap_pkg;

    localparam int DATA_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int FRAC_W      = 4;

    // Widths of the mapping datapath.
    localparam int DIFF_W    = DATA_W + 1;          // x - min, grid span
    localparam int PROD_W    = 2 * DIFF_W;          // (x - min) * span
    localparam int GLD_W     = DATA_W + DIFF_W;     // grid_low * (max - min)
    localparam int NUM_W     = PROD_W + 1;          // numerator
    localparam int QUO_W     = NUM_W - 1;           // numerator magnitude
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic signed [DATA_W-1:0] SCAN_MAX_SEED   = 16'sd480;
    localparam logic signed [DATA_W-1:0] SCAN_MIN_SEED   = 16'sd1920;
    localparam logic signed [DATA_W-1:0] GRID_LOW_RESET  = 16'sd0;
    localparam logic signed [DATA_W-1:0] GRID_HIGH_RESET = 16'sd63;
    localparam logic signed [DATA_W-1:0] POINT_MAX       = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] POINT_MIN       = 16'sh8000;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HIGH = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FILL   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_SCAN   = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_SCAN_END,
        ST_SCAN_FIN,
        ST_RD_WAIT,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_SAT,
        ST_PUT
    } state_t;

endpackage

// ===== sv/history_ring_autoscale_plot.sv =====
// Temperature history ring with min/max autoscaling and plot coordinate mapping.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   input    | in_valid, in_stall | action, sample
//   output   | out_valid, out_stall | plot_point, range_min, range_max
//   config   | cfg_write          | cfg_index, cfg_data
//
// Fill writes its sample to every entry, scan sweeps the whole sample memory,
// and read runs a restoring divider, one quotient bit per cycle, over the
// 34-bit magnitude of a 35-bit numerator, skipped when the range is empty.
// After reset a clearing pass writes zero to every entry of the memory, with
// in_stall high. A result waits in the output register while out_stall is
// high, and the next item is accepted meanwhile; that item's result then
// holds the block until the output register frees up.
module history_ring_autoscale_plot #(
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [hrap_pkg::ACTION_W-1:0]          action,
    input  logic signed [hrap_pkg::DATA_W-1:0]     sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [hrap_pkg::DATA_W-1:0]     plot_point,
    output logic signed [hrap_pkg::DATA_W-1:0]     range_min,
    output logic signed [hrap_pkg::DATA_W-1:0]     range_max,
    input  logic                                   cfg_write,
    input  logic [hrap_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [hrap_pkg::DATA_W-1:0]            cfg_data
);
    import hrap_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    // Sample memory
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] rdata_reg;

    // Control state
    state_t                   state_reg, state_next;
    logic [AW-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]            wp_reg, wp_next;
    logic [AW-1:0]            rp_reg, rp_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] grid_low_reg, grid_high_reg;
    logic                     out_valid_reg;
    logic                     scan_cmp_reg, scan_cmp_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    // Datapath
    logic signed [DATA_W-1:0] fill_reg, fill_next;
    logic signed [DATA_W-1:0] hi_reg, hi_next;
    logic signed [DATA_W-1:0] lo_reg, lo_next;
    logic signed [DIFF_W-1:0] dx_reg, dx_next;
    logic signed [DIFF_W-1:0] dg_reg, dg_next;
    logic [DATA_W-1:0]        d_reg, d_next;
    logic signed [PROD_W-1:0] prod1_reg, prod1_next;
    logic signed [GLD_W-1:0]  prod2_reg, prod2_next;
    logic                     neg_reg, neg_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic signed [DATA_W-1:0] point_reg, point_next;
    logic signed [DATA_W-1:0] plot_point_reg, range_min_reg, range_max_reg;

    logic                     accept_in;
    logic                     out_free;
    logic                     out_load;
    logic signed [DIFF_W-1:0] span;
    logic signed [DIFF_W-1:0] ceil_sum;
    logic signed [NUM_W-1:0]  num;
    logic [DIFF_W-1:0]        shifted;
    logic [DIFF_W-1:0]        reduced;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign plot_point = plot_point_reg;
    assign range_min  = range_min_reg;
    assign range_max  = range_max_reg;

    assign span     = {max_reg[DATA_W-1], max_reg} - {min_reg[DATA_W-1], min_reg};
    assign ceil_sum = ({hi_reg[DATA_W-1], hi_reg} + DIFF_W'(15)) & ~DIFF_W'(15);
    assign num      = {{(NUM_W-PROD_W){prod1_reg[PROD_W-1]}}, prod1_reg}
                    + {{(NUM_W-GLD_W){prod2_reg[GLD_W-1]}}, prod2_reg};
    assign shifted  = {rem_reg, quo_reg[QUO_W-1]};
    assign reduced  = shifted - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        scan_cmp_next = 1'b0;
        div_cnt_next  = div_cnt_reg;
        fill_next     = fill_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        dx_next       = dx_reg;
        dg_next       = dg_reg;
        d_next        = d_reg;
        prod1_next    = prod1_reg;
        prod2_next    = prod2_reg;
        neg_next      = neg_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        point_next    = point_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = fill_reg;
        mem_raddr     = rp_reg;
        out_load      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    case (action)
                        ACT_FILL:
                        begin
                            fill_next  = sample;
                            min_next   = sample;
                            max_next   = sample;
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        ACT_INSERT:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = wp_reg;
                            mem_wdata  = sample;
                            wp_next    = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
                            point_next = '0;
                            state_next = ST_PUT;
                        end
                        ACT_SCAN:
                        begin
                            hi_next    = SCAN_MAX_SEED;
                            lo_next    = SCAN_MIN_SEED;
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        ACT_READ:
                        begin
                            rp_next    = (rp_reg == LAST) ? '0 : rp_reg + 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    point_next = '0;
                    state_next = ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                mem_raddr     = cnt_reg;
                scan_cmp_next = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN_END:
            begin
                // The last entry is folded into the extremes at this edge.
                state_next = ST_SCAN_FIN;
            end
            ST_SCAN_FIN:
            begin
                min_next = {lo_reg[DATA_W-1:FRAC_W], {FRAC_W{1'b0}}};
                if (ceil_sum > DIFF_W'(POINT_MAX))
                begin
                    max_next = POINT_MAX;
                end
                else
                begin
                    max_next = ceil_sum[DATA_W-1:0];
                end
                rp_next    = wp_reg;
                point_next = '0;
                state_next = ST_PUT;
            end
            ST_RD_WAIT:
            begin
                dx_next = {rdata_reg[DATA_W-1], rdata_reg} - {min_reg[DATA_W-1], min_reg};
                dg_next = {grid_high_reg[DATA_W-1], grid_high_reg}
                        - {grid_low_reg[DATA_W-1], grid_low_reg};
                // The range never runs backward, so the difference fits unsigned.
                d_next  = span[DATA_W-1:0];
                if (span == '0)
                begin
                    point_next = grid_low_reg;
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod1_next = dx_reg * dg_reg;
                prod2_next = grid_low_reg * $signed({1'b0, d_reg});
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                neg_next     = num[NUM_W-1];
                quo_next     = num[NUM_W-1] ? QUO_W'(-num) : QUO_W'(num);
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring division of the magnitude, one quotient bit per cycle.
                if (shifted >= {1'b0, d_reg})
                begin
                    rem_next = reduced[DATA_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(QUO_W - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (!neg_reg)
                begin
                    point_next = (quo_reg > QUO_W'(32767)) ? POINT_MAX
                                                           : quo_reg[DATA_W-1:0];
                end
                else
                begin
                    point_next = (quo_reg > QUO_W'(32768)) ? POINT_MIN
                                                           : -quo_reg[DATA_W-1:0];
                end
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_cmp_reg)
        begin
            if (rdata_reg > hi_reg)
            begin
                hi_next = rdata_reg;
            end
            if (rdata_reg < lo_reg)
            begin
                lo_next = rdata_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            grid_low_reg  <= GRID_LOW_RESET;
            grid_high_reg <= GRID_HIGH_RESET;
            out_valid_reg <= 1'b0;
            scan_cmp_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            scan_cmp_reg <= scan_cmp_next;
            div_cnt_reg  <= div_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_GRID_LOW)
                begin
                    grid_low_reg <= $signed(cfg_data);
                end
                else if (cfg_index == CFG_GRID_HIGH)
                begin
                    grid_high_reg <= $signed(cfg_data);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg  <= fill_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        dx_reg    <= dx_next;
        dg_reg    <= dg_next;
        d_reg     <= d_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        neg_reg   <= neg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        point_reg <= point_next;
        if (out_load)
        begin
            plot_point_reg <= point_reg;
            range_min_reg  <= min_reg;
            range_max_reg  <= max_reg;
        end
    end

endmodule

// ===== bench/tb_history_ring_autoscale_plot.sv =====
// Self-checking testbench for the history ring autoscale plot block.
module tb_history_ring_autoscale_plot;
    import hrap_pkg::*;

    localparam int HIST_DEPTH     = 128;
    localparam int PTR_W          = $clog2(HIST_DEPTH);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct {
        logic signed [DATA_W-1:0] point;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } plot_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [ACTION_W-1:0]        action = ACT_FILL;
    logic signed [DATA_W-1:0]   sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DATA_W-1:0]   plot_point;
    logic signed [DATA_W-1:0]   range_min;
    logic signed [DATA_W-1:0]   range_max;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = CFG_GRID_LOW;
    logic [DATA_W-1:0]          cfg_data = '0;

    // Shadow copy of the history ring and its registers.
    logic signed [DATA_W-1:0]   hist_mem [HIST_DEPTH];
    logic [PTR_W-1:0]           wr_ptr = '0;
    logic [PTR_W-1:0]           rd_ptr = '0;
    logic signed [DATA_W-1:0]   hist_min = '0;
    logic signed [DATA_W-1:0]   hist_max = '0;
    logic signed [DATA_W-1:0]   grid_lo = GRID_LOW_RESET;
    logic signed [DATA_W-1:0]   grid_hi = GRID_HIGH_RESET;

    plot_result_t plot_queue [$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    history_ring_autoscale_plot #(
        .DEPTH(HIST_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plot_point (plot_point),
        .range_min  (range_min),
        .range_max  (range_max),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] map_to_grid(input logic signed [DATA_W-1:0] x);
        longint span;
        longint num;
        longint quo;
        span = longint'(hist_max) - longint'(hist_min);
        if (span == 0)
            return grid_lo;
        num = (longint'(x) - longint'(hist_min)) * (longint'(grid_hi) - longint'(grid_lo))
              + longint'(grid_lo) * span;
        quo = num / span;
        if (quo > longint'(POINT_MAX))
            quo = longint'(POINT_MAX);
        if (quo < longint'(POINT_MIN))
            quo = longint'(POINT_MIN);
        return quo[DATA_W-1:0];
    endfunction

    function automatic plot_result_t predict_plot(input action_t act,
                                                  input logic signed [DATA_W-1:0] smp);
        plot_result_t res;
        int hi_v;
        int lo_v;
        int ceil_v;
        res.point = '0;
        case (act)
            ACT_FILL:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = smp;
                hist_min = smp;
                hist_max = smp;
            end
            ACT_INSERT:
            begin
                hist_mem[wr_ptr] = smp;
                wr_ptr = wr_ptr + 1'b1;
            end
            ACT_SCAN:
            begin
                hi_v = int'(SCAN_MAX_SEED);
                lo_v = int'(SCAN_MIN_SEED);
                foreach (hist_mem[i])
                begin
                    if (int'(hist_mem[i]) > hi_v)
                        hi_v = int'(hist_mem[i]);
                    if (int'(hist_mem[i]) < lo_v)
                        lo_v = int'(hist_mem[i]);
                end
                // Floor and ceiling to whole degrees, with the ceiling clamped.
                lo_v = lo_v - (lo_v & 15);
                ceil_v = hi_v + 15;
                ceil_v = ceil_v - (ceil_v & 15);
                if (ceil_v > int'(POINT_MAX))
                    ceil_v = int'(POINT_MAX);
                hist_min = lo_v[DATA_W-1:0];
                hist_max = ceil_v[DATA_W-1:0];
                rd_ptr = wr_ptr;
            end
            default:
            begin
                res.point = map_to_grid(hist_mem[rd_ptr]);
                rd_ptr = rd_ptr + 1'b1;
            end
        endcase
        res.lo = hist_min;
        res.hi = hist_max;
        return res;
    endfunction

    // Valid is held until the item is taken; it is lowered on an idle cycle or while results drain.
    task automatic send_item(input action_t act, input logic signed [DATA_W-1:0] smp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        plot_queue.push_back(predict_plot(act, smp));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (plot_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_grid(input logic signed [DATA_W-1:0] lo,
                              input logic signed [DATA_W-1:0] hi);
        wait_results_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_GRID_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_GRID_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        grid_lo = lo;
        grid_hi = hi;
    endtask

    function automatic logic signed [DATA_W-1:0] random_sample();
        logic signed [DATA_W-1:0] v;
        int t;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1:
            begin
                t = int'($urandom_range(0, 2800)) - 400;
                v = t[DATA_W-1:0];
            end
            2:
            begin
                if ($urandom_range(0, 1) == 1)
                    v = POINT_MAX - 16'($urandom_range(0, 3));
                else
                    v = POINT_MIN + 16'($urandom_range(0, 3));
            end
            default:
            begin
                t = int'($urandom_range(0, 64)) - 32;
                v = t[DATA_W-1:0];
            end
        endcase
        return v;
    endfunction

    // Reads before any scan see an empty range; a scan of the cleared ring
    // picks up the maximum seed.
    task automatic test_reset_state();
        send_item(ACT_READ, 16'sh7FFF);
        send_item(ACT_SCAN, 16'sh8000);
        send_item(ACT_READ, 16'sd0);
    endtask

    task automatic test_fill_extremes();
        send_item(ACT_FILL, POINT_MAX);
        send_item(ACT_READ, 16'sd0);
        // The ceiling of the largest sample overflows and must clamp.
        send_item(ACT_SCAN, 16'sd0);
        send_item(ACT_READ, 16'sd0);
        send_item(ACT_FILL, POINT_MIN);
        send_item(ACT_SCAN, 16'sd0);
        send_item(ACT_READ, 16'sd0);
    endtask

    task automatic test_scan_seeds();
        send_item(ACT_FILL, 16'sd2000);
        send_item(ACT_SCAN, 16'sd0);
        // A negative sample with a fraction floors toward minus infinity.
        send_item(ACT_INSERT, -16'sd25);
        send_item(ACT_INSERT, 16'sd487);
        send_item(ACT_SCAN, 16'sd0);
    endtask

    task automatic test_grid_saturation();
        write_grid(POINT_MIN, POINT_MAX);
        send_item(ACT_FILL, 16'sd0);
        send_item(ACT_SCAN, 16'sd0);
        send_item(ACT_INSERT, POINT_MAX);
        send_item(ACT_INSERT, POINT_MIN);
        send_item(ACT_READ, 16'sd0);
        send_item(ACT_READ, 16'sd0);
        // A negative quotient that is not whole truncates toward zero.
        write_grid(-16'sd100, 16'sd100);
        send_item(ACT_INSERT, -16'sd7);
        send_item(ACT_READ, 16'sd0);
    endtask

    // Mostly insert runs followed by a scan and a mix of reads and inserts,
    // with fills and arbitrary items as noise.
    task automatic test_random_traffic(input logic signed [DATA_W-1:0] lo,
                                       input logic signed [DATA_W-1:0] hi);
        int sent;
        int n;
        int r;
        write_grid(lo, hi);
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    send_item(ACT_INSERT, random_sample());
                send_item(ACT_SCAN, random_sample());
                sent += n + 1;
                n = $urandom_range(1, 12);
                repeat (n)
                    send_item(($urandom_range(0, 3) == 0) ? ACT_INSERT : ACT_READ,
                              random_sample());
                sent += n;
            end
            else if (r < 75)
            begin
                send_item(ACT_FILL, random_sample());
                sent += 1;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(action_t'($urandom_range(0, 3)), random_sample());
                sent += n;
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        plot_result_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (plot_queue.size() == 0)
            begin
                $error("unexpected item: plot_point %0d range_min %0d range_max %0d",
                       plot_point, range_min, range_max);
                fail_count++;
            end
            else
            begin
                want = plot_queue.pop_front();
                if (plot_point !== want.point)
                begin
                    $error("plot_point: expected %0d, got %0d", want.point, plot_point);
                    fail_count++;
                end
                if (range_min !== want.lo)
                begin
                    $error("range_min: expected %0d, got %0d", want.lo, range_min);
                    fail_count++;
                end
                if (range_max !== want.hi)
                begin
                    $error("range_max: expected %0d, got %0d", want.hi, range_max);
                    fail_count++;
                end
            end
        end
    end

    // Counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        send_idle_pct = 27;
        recv_idle_pct = 53;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_fill_extremes();
        test_scan_seeds();
        test_grid_saturation();

        // Each phase starts with a grid write, which first drains every result.
        test_random_traffic(-16'sd100, 16'sd400);
        send_idle_pct = 53;
        recv_idle_pct = 27;
        test_random_traffic(POINT_MAX, POINT_MIN);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(16'($urandom), 16'($urandom));

        wait_results_drained();
        repeat (2 * HIST_DEPTH + 16)
            @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
